[design/lpm_pkg.sv]
// ============================================================================
// lpm_pkg: shared types and constants of the longest-prefix-match router
// Holds the word formats of both channels, the result codes, the controller
// state encoding, the controller/datapath handshake structs and the mask
// helper.
// ============================================================================
`default_nettype none

package lpm_pkg;

    // Default route table depth.
    localparam int TABLE_ENTRIES = 16;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int ITF_W      = 3;
    localparam int TTL_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int MAX_PREFIX = 32;

    // Command codes carried in the input word.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FORWARDED   = 3'd0,
        ST_NO_ROUTE    = 3'd1,
        ST_TTL_EXPIRED = 3'd2,
        ST_ADDED       = 3'd3,
        ST_FULL        = 3'd4
    } t_status;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] rt_prefix;
        logic [LEN_W-1:0]  rt_len;
        logic              has_next_hop;
        logic [ADDR_W-1:0] next_hop_address;
        logic [ITF_W-1:0]  interface_index;
        logic [ADDR_W-1:0] dst_address;
        logic [TTL_W-1:0]  ttl_in;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITF_W-1:0]    out_interface;
        logic [ADDR_W-1:0]   next_hop_out;
        logic [TTL_W-1:0]    ttl_out;
    } t_out_word;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic              has_hop;
        logic [ADDR_W-1:0] hop;
        logic [ITF_W-1:0]  itf;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ADD    = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic add_commit;
        logic finish_commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic item_is_add;
        logic scan_done;
        logic out_free;
    } t_sts;

    // Mask of the high-order len bits; a length of zero matches everything.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(MAX_PREFIX) - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

[design/lpm_ctrl.sv]
// ============================================================================
// lpm_ctrl: sequencing controller of the router
// Accepts one word at a time, steps the table scan and commits the result
// into the output register when it is free.
// ============================================================================
`default_nettype none

module lpm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lpm_pkg::t_sts i_sts,
    output lpm_pkg::t_cmd      o_cmd
);

    lpm_pkg::t_state r_state;
    lpm_pkg::t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lpm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_in_valid && i_sts.item_is_add) ? lpm_pkg::S_ADD
                                                                : lpm_pkg::S_SCAN;
                end
            end
            lpm_pkg::S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add_commit = 1'b1;
                    n_state = lpm_pkg::S_IDLE;
                end
            end
            lpm_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = lpm_pkg::S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            lpm_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish_commit = 1'b1;
                    n_state = lpm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lpm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // A result is only committed when the output register can take it.
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.add_commit || o_cmd.finish_commit) |-> i_sts.out_free)
        else $error("result committed while output register busy");

    // The scan never steps past the stored entries.
    a_no_step_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_step |-> !i_sts.scan_done)
        else $error("scan stepped beyond table contents");

    // The state register always holds exactly one active state.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");
`endif

endmodule

`default_nettype wire

[design/lpm_datapath.sv]
// ============================================================================
// lpm_datapath: route table, scan comparator and output register
// Holds the route memory and its fill count, compares one entry per cycle
// against the destination and keeps the best match so far.
// ============================================================================
`default_nettype none

module lpm_datapath #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lpm_pkg::t_in_word   i_in_word,
    input  wire lpm_pkg::t_cmd       i_cmd,
    output lpm_pkg::t_sts            o_sts,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output lpm_pkg::t_out_word       o_out_word
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    lpm_pkg::t_entry   mem [TABLE_ENTRIES];
    lpm_pkg::t_entry   r_rd_data;
    logic              r_rd_valid;

    lpm_pkg::t_in_word r_item;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;

    logic                       r_found;
    logic [lpm_pkg::LEN_W-1:0]  r_best_len;
    logic                       r_best_has_hop;
    logic [lpm_pkg::ADDR_W-1:0] r_best_hop;
    logic [lpm_pkg::ITF_W-1:0]  r_best_itf;

    logic                       r_out_valid;
    lpm_pkg::t_out_word         r_out_word;
    lpm_pkg::t_out_word         n_out_word;

    logic                       out_free;
    logic                       table_full;
    logic                       hit;
    logic [lpm_pkg::ADDR_W-1:0] mask;
    logic [lpm_pkg::LEN_W-1:0]  sat_len;
    lpm_pkg::t_entry            wr_entry;

    assign out_free   = !r_out_valid || i_out_ready;
    assign table_full = (r_count == CNT_W'(TABLE_ENTRIES));

    assign o_sts.item_is_add = (i_in_word.command == lpm_pkg::CMD_ADD);
    assign o_sts.scan_done   = (r_idx == r_count);
    assign o_sts.out_free    = out_free;

    assign sat_len = (r_item.rt_len > lpm_pkg::LEN_W'(lpm_pkg::MAX_PREFIX))
                   ? lpm_pkg::LEN_W'(lpm_pkg::MAX_PREFIX) : r_item.rt_len;

    always_comb begin
        wr_entry.prefix  = r_item.rt_prefix;
        wr_entry.length  = sat_len;
        wr_entry.has_hop = r_item.has_next_hop;
        wr_entry.hop     = r_item.next_hop_address;
        wr_entry.itf     = r_item.interface_index;
    end

    // Table memory: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && !table_full) begin
            mem[r_count[IDX_W-1:0]] <= wr_entry;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    assign mask = lpm_pkg::prefix_mask(r_rd_data.length);
    assign hit  = r_rd_valid
               && ((r_item.dst_address & mask) == (r_rd_data.prefix & mask))
               && (!r_found || (r_rd_data.length > r_best_len));

    // Result word formed at commit time.
    always_comb begin
        n_out_word = '0;
        if (i_cmd.add_commit) begin
            n_out_word.status = table_full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
        end else if (!r_found) begin
            n_out_word.status = lpm_pkg::ST_NO_ROUTE;
        end else if (r_item.ttl_in <= lpm_pkg::TTL_W'(1)) begin
            n_out_word.status = lpm_pkg::ST_TTL_EXPIRED;
        end else begin
            n_out_word.status        = lpm_pkg::ST_FORWARDED;
            n_out_word.out_interface = r_best_itf;
            n_out_word.next_hop_out  = r_best_has_hop ? r_best_hop : r_item.dst_address;
            n_out_word.ttl_out       = r_item.ttl_in - lpm_pkg::TTL_W'(1);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        if (hit) begin
            r_best_len     <= r_rd_data.length;
            r_best_has_hop <= r_rd_data.has_hop;
            r_best_hop     <= r_rd_data.hop;
            r_best_itf     <= r_rd_data.itf;
        end
        if (i_cmd.add_commit || i_cmd.finish_commit) begin
            r_out_word <= n_out_word;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_step;
            if (i_cmd.load_item) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.add_commit && !table_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.add_commit || i_cmd.finish_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("route count exceeds table depth");

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan index beyond fill count");

    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status == lpm_pkg::ST_FORWARDED))
            |-> (r_out_word.ttl_out != '0))
        else $error("forwarded word with zero ttl");
`endif

endmodule

`default_nettype wire

[design/longest_prefix_match_router.sv]
// ============================================================================
// longest_prefix_match_router: IPv4 route table with longest-prefix lookup
// Stores routes on request and answers each datagram lookup with one word.
// ============================================================================
// Usage. Both channels are valid/ready; a word moves on an edge where both
// are high. Each input word yields exactly one output word. An add word
// stores a route in the next free slot (prefix lengths above 32 are kept as
// 32) and answers "route added", or "table full" once TABLE_ENTRIES routes
// are held. A route word scans the stored routes one per cycle through the
// table memory's single registered read port; the longest match wins and the
// earliest added route wins a tie. It answers forwarded (interface, next hop
// or the destination for a directly attached route, ttl minus one), no route,
// or ttl expired when ttl_in is 0 or 1.
// Sequencing. An add is committed to the output register as soon as that
// register is free; a lookup scans the stored routes one per cycle, then
// decides in a finish state and commits likewise. The block accepts a new
// word in the cycle after the previous result is loaded, even while that
// result still waits in the output register, so a new word can be taken
// before the receiver takes the last result. If the receiver stalls, the
// finished result is held and the next item waits for the register before
// committing.
// Reset (synchronous, active low) empties the table and the output register.
// ============================================================================
`default_nettype none

module longest_prefix_match_router #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lpm_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output lpm_pkg::t_out_word     o_out_word
);

    // Command and status between the sequencer and the table datapath.
    lpm_pkg::t_cmd cmd;
    lpm_pkg::t_sts sts;

    lpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
